[rtl/fpba_pkg.sv]
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

    // Stream field widths
    localparam int BLK_FIELD_W = 4;
    localparam int AMT_FIELD_W = 16;
    localparam int TDATA_W     = 24;

    // Configuration register widths and indexes
    localparam int CFG_DATA_W  = 5;
    localparam int BCNT_W      = 5;
    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;
    localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd16;

    // Item kinds carried in tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2,
        MODE_NEXT  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

[rtl/fit_policy_block_allocator_unit.sv]
// Top level of the fit-policy block allocator: ring of capacity cells and control.
//
// Block capacities sit in a ring of MAX_BLOCKS cells that, during a scan,
// rotates one place per cycle past a single compare stage. A load transfer
// writes its cell directly and its result passes through the FINISH state to the
// output register. An allocate transfer rotates the ring once round (whatever
// block_count is), then writes back the reduced capacity in the WRITE state and
// presents the result from the FINISH state, one item at a
// time. The next item is accepted as soon as the previous result has moved into
// the output register, even if that result has not yet been taken. The table
// needs no clearing after reset; every block must be loaded before use.
module fit_policy_block_allocator_unit
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // block_index[3:0], amount[19:4], zeros
    input  logic                  s_tuser,   // func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // chosen_block[3:0], capacity_left[19:4], zeros
    output logic                  m_tuser    // granted
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_BLOCKS - 1);

    state_t state_reg, state_next;

    mode_t             fit_mode_reg;
    logic [BCNT_W-1:0] block_count_reg;
    logic [IDX_W-1:0]  next_pointer_reg, next_pointer_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [SIZE_BITS-1:0] need_reg, need_next;

    logic                   res_granted_reg, res_granted_next;
    logic [BLK_FIELD_W-1:0] res_block_reg, res_block_next;
    logic [AMT_FIELD_W-1:0] res_cap_reg, res_cap_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic [BLK_FIELD_W-1:0] in_block;
    logic [AMT_FIELD_W-1:0] in_amount;
    logic [SIZE_BITS-1:0]   in_size;
    logic                   in_xfer;
    logic                   load_ok;
    logic                   out_free;

    logic [CNT_W-1:0] blocks_used;
    logic [IDX_W-1:0] scan_start;

    logic                 wr_any;
    logic [IDX_W-1:0]     wr_idx;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 shift_en;

    logic                 scan_found;
    logic [IDX_W-1:0]     scan_sel;
    logic [SIZE_BITS-1:0] scan_cap;
    logic [SIZE_BITS-1:0] cap_after;

    logic [SIZE_BITS-1:0] cap [MAX_BLOCKS];

    assign in_block  = s_tdata[BLK_FIELD_W-1:0];
    assign in_amount = s_tdata[BLK_FIELD_W +: AMT_FIELD_W];
    assign in_size   = SIZE_BITS'(in_amount);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign load_ok   = (32'(in_block) < 32'(MAX_BLOCKS));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign shift_en  = (state_reg == ST_SCAN);
    assign cap_after = scan_cap - need_reg;

    // block_count of zero acts as one, above the table as the table size
    always_comb
    begin
        if (block_count_reg == '0)
        begin
            blocks_used = CNT_W'(1);
        end
        else if (32'(block_count_reg) > 32'(MAX_BLOCKS))
        begin
            blocks_used = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            blocks_used = CNT_W'(block_count_reg);
        end
    end

    assign scan_start = (CNT_W'(next_pointer_reg) < blocks_used) ? next_pointer_reg : '0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= BCNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FIT_MODE:    fit_mode_reg    <= mode_t'(cfg_wdata[1:0]);
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[BCNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ring of cells; cell 0 is the head seen by the scan
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % MAX_BLOCKS;

        fpba_cell #(
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (cap[NXT]),
            .wr_en    (wr_any && (wr_idx == IDX_W'(i))),
            .wr_data  (wr_data),
            .cap      (cap[i])
        );
    end

    fpba_scan #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (in_xfer),
        .step_en     (shift_en),
        .mode        (fit_mode_reg),
        .need        (need_reg),
        .cap         (cap[0]),
        .step        (step_reg),
        .blocks_used (blocks_used),
        .start       (scan_start),
        .found       (scan_found),
        .sel         (scan_sel),
        .sel_cap     (scan_cap)
    );

    // cell write port: loads from IDLE, write-back after a scan
    always_comb
    begin
        wr_any  = 1'b0;
        wr_idx  = scan_sel;
        wr_data = cap_after;
        if ((state_reg == ST_IDLE) && in_xfer && (s_tuser == FUNC_LOAD) && load_ok)
        begin
            wr_any  = 1'b1;
            wr_idx  = IDX_W'(in_block);
            wr_data = in_size;
        end
        else if ((state_reg == ST_WRITE) && scan_found)
        begin
            wr_any = 1'b1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        need_next         = need_reg;
        next_pointer_next = next_pointer_reg;
        res_granted_next  = res_granted_reg;
        res_block_next    = res_block_reg;
        res_cap_next      = res_cap_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == FUNC_LOAD)
                    begin
                        res_granted_next = load_ok;
                        res_block_next   = in_block;
                        res_cap_next     = load_ok ? AMT_FIELD_W'(in_size) : '0;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        need_next  = in_size;
                        step_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                res_granted_next = scan_found;
                res_block_next   = scan_found ? BLK_FIELD_W'(scan_sel) : '0;
                res_cap_next     = scan_found ? AMT_FIELD_W'(cap_after) : '0;
                if (scan_found && (fit_mode_reg == MODE_NEXT))
                begin
                    next_pointer_next = scan_sel;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(TDATA_W - BLK_FIELD_W - AMT_FIELD_W){1'b0}},
                                     res_cap_reg, res_block_reg};
                    m_tuser_next  = res_granted_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            next_pointer_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            next_pointer_reg <= next_pointer_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg        <= need_next;
        res_granted_reg <= res_granted_next;
        res_block_reg   <= res_block_next;
        res_cap_reg     <= res_cap_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one item in flight: no second transfer straight after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // every scan starts with the ring at home
    a_scan_from_home: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SCAN) |-> (step_reg == '0))
        else $error("scan started with the ring rotated");

    // a chosen block always lies within the blocks in use
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && scan_found) |-> (CNT_W'(scan_sel) < blocks_used))
        else $error("chosen block outside the blocks in use");

endmodule

[rtl/fpba_cell.sv]
// One capacity cell of the rotating ring.
module fpba_cell
    import fpba_pkg::*;
#(
    parameter int SIZE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic [SIZE_BITS-1:0] shift_in,
    input  logic                 wr_en,
    input  logic [SIZE_BITS-1:0] wr_data,
    output logic [SIZE_BITS-1:0] cap
);

    logic [SIZE_BITS-1:0] cap_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cap_reg <= wr_data;
        end
        else if (shift_en)
        begin
            cap_reg <= shift_in;
        end
    end

    assign cap = cap_reg;

endmodule

[rtl/fpba_scan.sv]
// Candidate selection at the head of the ring, one entry per cycle while step_en is high.
module fpba_scan
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    localparam int IDX_W     = $clog2(MAX_BLOCKS),
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 step_en,
    input  mode_t                mode,
    input  logic [SIZE_BITS-1:0] need,
    input  logic [SIZE_BITS-1:0] cap,
    input  logic [IDX_W-1:0]     step,
    input  logic [CNT_W-1:0]     blocks_used,
    input  logic [IDX_W-1:0]     start,
    output logic                 found,
    output logic [IDX_W-1:0]     sel,
    output logic [SIZE_BITS-1:0] sel_cap
);

    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     sel_reg, sel_next;
    logic [SIZE_BITS-1:0] sel_cap_reg, sel_cap_next;
    // first fit at or after the next-fit start
    logic                 hi_found_reg, hi_found_next;
    logic [IDX_W-1:0]     hi_sel_reg, hi_sel_next;
    logic [SIZE_BITS-1:0] hi_cap_reg, hi_cap_next;

    logic fits;
    logic take;

    assign fits = (CNT_W'(step) < blocks_used) && (cap >= need);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (mode)
                    MODE_BEST:  take = (sel_cap_reg >= cap);
                    MODE_WORST: take = (sel_cap_reg < cap);
                    default:    take = 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        found_next    = found_reg;
        sel_next      = sel_reg;
        sel_cap_next  = sel_cap_reg;
        hi_found_next = hi_found_reg;
        hi_sel_next   = hi_sel_reg;
        hi_cap_next   = hi_cap_reg;
        if (clear)
        begin
            found_next    = 1'b0;
            hi_found_next = 1'b0;
        end
        else if (step_en)
        begin
            if (take)
            begin
                found_next   = 1'b1;
                sel_next     = step;
                sel_cap_next = cap;
            end
            if (fits && !hi_found_reg && (step >= start))
            begin
                hi_found_next = 1'b1;
                hi_sel_next   = step;
                hi_cap_next   = cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            hi_found_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_next;
            hi_found_reg <= hi_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        sel_cap_reg <= sel_cap_next;
        hi_sel_reg  <= hi_sel_next;
        hi_cap_reg  <= hi_cap_next;
    end

    // next fit wraps to the overall first fit when nothing fits at or after the start
    always_comb
    begin
        if ((mode == MODE_NEXT) && hi_found_reg)
        begin
            found   = 1'b1;
            sel     = hi_sel_reg;
            sel_cap = hi_cap_reg;
        end
        else
        begin
            found   = found_reg;
            sel     = sel_reg;
            sel_cap = sel_cap_reg;
        end
    end

endmodule

[tb/tb.sv]
// Self-checking testbench for the fit-policy block allocator unit.
module tb
    import fpba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BLOCKS = 16;
    localparam int HOLD_LEN   = 300;

    typedef struct packed {
        logic        granted;
        logic [3:0]  block;
        logic [15:0] left;
    } grant_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    // shadow of the allocator state
    bit [15:0]   cap_shadow [MAX_BLOCKS];
    bit [3:0]    next_start;
    mode_t       fit_policy;
    bit [4:0]    block_limit;

    grant_t      pending_grants [$];
    int          fault_count = 0;
    int          src_pct     = 0;
    int          sink_pct    = 0;
    int          hold_cycles = 0;

    fit_policy_block_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic int blocks_used();
        if (block_limit == 0)
            return 1;
        if (block_limit > MAX_BLOCKS)
            return MAX_BLOCKS;
        return block_limit;
    endfunction

    function automatic void predict_grant(logic func, logic [3:0] idx, logic [15:0] amt);
        grant_t g;
        int     n;
        int     id;
        int     sel;
        bit     hit;
        g   = '0;
        hit = 1'b0;
        sel = 0;
        if (func == FUNC_LOAD)
        begin
            cap_shadow[idx] = amt;
            g.granted = 1'b1;
            g.block   = idx;
            g.left    = amt;
        end
        else
        begin
            n = blocks_used();
            if (fit_policy == MODE_NEXT)
            begin
                id = (next_start < n) ? next_start : 0;
                for (int i = 0; i < n && !hit; i++)
                begin
                    if (cap_shadow[id] >= amt)
                    begin
                        hit = 1'b1;
                        sel = id;
                    end
                    else
                        id = (id + 1 >= n) ? 0 : id + 1;
                end
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (cap_shadow[i] >= amt)
                    begin
                        if (!hit)
                        begin
                            hit = 1'b1;
                            sel = i;
                            if (fit_policy == MODE_FIRST)
                                break;
                        end
                        else if (fit_policy == MODE_BEST)
                        begin
                            // ties go to the later block
                            if (cap_shadow[sel] >= cap_shadow[i])
                                sel = i;
                        end
                        else if (fit_policy == MODE_WORST)
                        begin
                            if (cap_shadow[sel] < cap_shadow[i])
                                sel = i;
                        end
                    end
                end
            end
            if (hit)
            begin
                cap_shadow[sel] = cap_shadow[sel] - amt;
                if (fit_policy == MODE_NEXT)
                    next_start = sel[3:0];
                g.granted = 1'b1;
                g.block   = sel[3:0];
                g.left    = cap_shadow[sel];
            end
        end
        pending_grants.push_back(g);
    endfunction

    function automatic void flag_fault(string why);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", why);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.granted = m_tuser;
            got.block   = m_tdata[3:0];
            got.left    = m_tdata[19:4];
            if (pending_grants.size() == 0)
                flag_fault($sformatf("unexpected result: granted %0b block %0d left %0d",
                                     got.granted, got.block, got.left));
            else
            begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted || got.block !== want.block ||
                    got.left !== want.left)
                    flag_fault($sformatf(
                        "mismatch: exp granted %0b block %0d left %0d, got %0b %0d %0d",
                        want.granted, want.block, want.left,
                        got.granted, got.block, got.left));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_pct);
        end
    end

    task automatic set_idle(idle_t kind);
        src_pct  = (kind == IDLE_SRC)  ? 61 : (kind == IDLE_BOTH) ? 6 : 0;
        sink_pct = (kind == IDLE_SINK) ? 61 : (kind == IDLE_BOTH) ? 6 : 0;
    endtask

    task automatic send_item(logic func, logic [3:0] idx, logic [15:0] amt);
        if ($urandom_range(0, 99) < src_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while ($urandom_range(0, 99) < src_pct)
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, amt, idx};
        do
            @(posedge clk);
        while (!s_tready);
        predict_grant(func, idx, amt);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_grants.size() == 0);
    endtask

    task automatic write_cfg(logic addr, logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == REG_FIT_MODE)
            fit_policy = mode_t'(val[1:0]);
        else
            block_limit = val;
    endtask

    // mix of loads and requests, requests mostly sized to fit somewhere
    task automatic random_items(int count);
        int          r;
        logic [15:0] amt;
        logic [15:0] target;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 9);
            if ($urandom_range(0, 99) < 30)
            begin
                if (r == 0)
                    amt = 16'd0;
                else if (r == 1)
                    amt = 16'hFFFF;
                else if (r < 5)
                    amt = 16'($urandom_range(0, 255));
                else
                    amt = 16'($urandom);
                send_item(FUNC_LOAD, 4'($urandom_range(0, 15)), amt);
            end
            else
            begin
                target = cap_shadow[$urandom_range(0, blocks_used() - 1)];
                if (r == 0)
                    amt = 16'd0;
                else if (r < 7)
                    amt = 16'($urandom_range(0, target));
                else if (r < 9)
                    amt = 16'($urandom);
                else
                    amt = 16'hFFFF;
                send_item(FUNC_ALLOC, 4'($urandom), amt);
            end
        end
    endtask

    task automatic test_directed_fits();
        set_idle(IDLE_NONE);
        write_cfg(REG_BLOCK_COUNT, 5'd4);
        send_item(FUNC_LOAD, 4'd0, 16'd0);
        send_item(FUNC_LOAD, 4'd1, 16'hFFFF);
        send_item(FUNC_LOAD, 4'd2, 16'd100);
        send_item(FUNC_LOAD, 4'd3, 16'd100);
        send_item(FUNC_LOAD, 4'd15, 16'hFFFF);   // past block count, still acknowledged
        send_item(FUNC_ALLOC, 4'hF, 16'd0);      // zero request takes empty block 0
        send_item(FUNC_ALLOC, 4'd0, 16'd50);
        write_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_BEST));
        send_item(FUNC_ALLOC, 4'd0, 16'd100);    // equal sizes: later block wins
        send_item(FUNC_ALLOC, 4'd0, 16'd1);
        write_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_WORST));
        send_item(FUNC_LOAD, 4'd2, 16'd65485);
        send_item(FUNC_ALLOC, 4'd0, 16'd10);     // equal sizes: earlier block wins
        send_item(FUNC_ALLOC, 4'd0, 16'hFFFF);   // nothing fits
        write_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_NEXT));
        send_item(FUNC_ALLOC, 4'd0, 16'd5);
        send_item(FUNC_ALLOC, 4'd0, 16'd65476);
        send_item(FUNC_ALLOC, 4'd0, 16'hFFFF);   // miss leaves the pointer alone
        write_cfg(REG_BLOCK_COUNT, 5'd2);        // pointer now past the blocks in use
        send_item(FUNC_ALLOC, 4'd0, 16'd0);
        write_cfg(REG_BLOCK_COUNT, 5'd0);        // behaves as a single block
        send_item(FUNC_ALLOC, 4'd0, 16'd0);
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < MAX_BLOCKS; i++)
            send_item(FUNC_LOAD, 4'(i), 16'($urandom));
    endtask

    task automatic test_backpressure();
        write_cfg(REG_BLOCK_COUNT, 5'd16);
        set_idle(IDLE_NONE);
        @(posedge clk);
        hold_cycles = HOLD_LEN;
        random_items(24);
    endtask

    task automatic test_random_phases();
        mode_t      ph_mode  [10] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_NEXT,
                                      MODE_NEXT, MODE_BEST, MODE_FIRST, MODE_WORST,
                                      MODE_NEXT, MODE_FIRST};
        logic [4:0] ph_count [10] = '{5'd16, 5'd16, 5'd8, 5'd16, 5'd5,
                                      5'd1, 5'd31, 5'd17, 5'd0, 5'd12};
        idle_t      ph_idle  [10] = '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH, IDLE_SRC,
                                      IDLE_SINK, IDLE_BOTH, IDLE_NONE, IDLE_SINK, IDLE_SRC};
        for (int p = 0; p < 10; p++)
        begin
            write_cfg(REG_FIT_MODE, CFG_DATA_W'(ph_mode[p]));
            write_cfg(REG_BLOCK_COUNT, ph_count[p]);
            set_idle(ph_idle[p]);
            random_items(88);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        next_start  = '0;
        fit_policy  = MODE_FIRST;
        block_limit = BCNT_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_fits();
        test_table_fill();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (MAX_BLOCKS + 24) @(posedge clk);
        if (fault_count == 0)
            $display("[fit_policy_block_allocator_unit] OK");
        else
            $display("[fit_policy_block_allocator_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[fit_policy_block_allocator_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/fpba_pkg.sv
rtl/fpba_cell.sv
rtl/fpba_scan.sv
rtl/fit_policy_block_allocator_unit.sv
tb/tb.sv
